[rtl/stbs_pkg.sv]
`default_nettype none

package stbs_pkg;

   // Fixed field widths of the channels
   localparam int IDX_W  = 10;
   localparam int VAL_W  = 32;
   localparam int SIZE_W = 11;
   // Common width for index arithmetic, wide enough for the largest table depth
   localparam int WIDE_W = 17;

   // Item kinds on the request channel
   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_SEARCH = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic write;    // store one table entry
      logic init;     // capture key and set up the search bounds
      logic probe;    // issue a table read at the midpoint
      logic step;     // read data is valid: narrow the bounds
      logic finish;   // capture the search outcome
      logic publish;  // move the outcome into the output register
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic empty;    // search range is empty before the first probe
      logic hit;      // probed entry equals the key
      logic more;     // range left after this probe is not empty
   } dp_status_type;

endpackage

`default_nettype wire

[rtl/stbs_req_if.sv]
`default_nettype none

interface stbs_req_if;
   logic                                valid;
   logic                                ready;
   logic                                action;
   logic        [stbs_pkg::IDX_W-1:0]   write_index;
   logic signed [stbs_pkg::VAL_W-1:0]   entry_value;
   logic signed [stbs_pkg::VAL_W-1:0]   search_key;

   modport source (output valid, action, write_index, entry_value, search_key, input ready);
   modport sink   (input valid, action, write_index, entry_value, search_key, output ready);
endinterface

`default_nettype wire

[rtl/stbs_rsp_if.sv]
`default_nettype none

interface stbs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         found;
   logic [stbs_pkg::IDX_W-1:0]   match_index;

   modport source (output valid, found, match_index, input ready);
   modport sink   (input valid, found, match_index, output ready);
endinterface

`default_nettype wire

[rtl/stbs_csr_if.sv]
`default_nettype none

interface stbs_csr_if;
   logic                          valid;
   logic                          ready;
   logic [stbs_pkg::SIZE_W-1:0]   table_size;

   modport source (output valid, table_size, input ready);
   modport sink   (input valid, table_size, output ready);
endinterface

`default_nettype wire

[rtl/stbs_ram.sv]
`default_nettype none

module stbs_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word with a registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/stbs_datapath.sv]
`default_nettype none

module stbs_datapath #(
   parameter int TABLE_DEPTH = 1024,
   parameter int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   input  wire logic        [stbs_pkg::SIZE_W-1:0]  csr_table_size,
   input  wire logic        [stbs_pkg::IDX_W-1:0]   req_write_index,
   input  wire logic signed [stbs_pkg::VAL_W-1:0]   req_entry_value,
   input  wire logic signed [stbs_pkg::VAL_W-1:0]   req_search_key,
   input  wire stbs_pkg::ctrl_cmd_type              cmd,
   output stbs_pkg::dp_status_type                  status,
   output logic                                     rsp_found,
   output logic             [stbs_pkg::IDX_W-1:0]   rsp_match_index
);

   localparam int WW    = stbs_pkg::WIDE_W;
   localparam int CNT_W = ADDR_W + 1;
   localparam logic [WW-1:0] DEPTH_WIDE = WW'(TABLE_DEPTH);

   logic [stbs_pkg::SIZE_W-1:0]        table_size_ff;
   logic signed [stbs_pkg::VAL_W-1:0]  key_ff;
   logic [CNT_W-1:0]                   low_ff;
   logic [CNT_W-1:0]                   hi1_ff;     // high bound plus one
   logic [ADDR_W-1:0]                  mid_ff;
   logic                               res_found_ff;
   logic [stbs_pkg::IDX_W-1:0]         res_idx_ff;
   logic                               rsp_found_ff;
   logic [stbs_pkg::IDX_W-1:0]         rsp_idx_ff;

   logic [WW-1:0]                      size_wide;
   logic [WW-1:0]                      size_clamp;
   logic [WW-1:0]                      widx_wide;
   logic [WW-1:0]                      mid_wide;
   logic                               wr_ok;
   logic signed [stbs_pkg::VAL_W-1:0]  rd_entry;
   logic                               key_lt;
   logic [CNT_W-1:0]                   upd_low;
   logic [CNT_W-1:0]                   upd_hi1;
   logic [CNT_W-1:0]                   src_low;
   logic [CNT_W-1:0]                   src_hi1;
   logic [CNT_W:0]                     mid_sum;
   logic [ADDR_W-1:0]                  mid_in;
   logic                               hit_now;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= '0;
      end else if (csr_valid) begin
         table_size_ff <= csr_table_size;
      end
   end

   // Saturate the covered size to the table depth
   always_comb begin
      size_wide  = WW'(table_size_ff);
      size_clamp = (size_wide > DEPTH_WIDE) ? DEPTH_WIDE : size_wide;
   end

   // Drop loads beyond the table
   assign widx_wide = WW'(req_write_index);
   assign wr_ok     = widx_wide < DEPTH_WIDE;

   stbs_ram #(
      .WIDTH  (stbs_pkg::VAL_W),
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.write & wr_ok),
      .wr_addr (widx_wide[ADDR_W-1:0]),
      .wr_data (req_entry_value),
      .rd_addr (mid_in),
      .rd_data (rd_entry)
   );

   // Narrow the bounds from the entry just read
   always_comb begin
      key_lt  = key_ff < rd_entry;
      hit_now = key_ff == rd_entry;
      upd_hi1 = key_lt ? {1'b0, mid_ff} : hi1_ff;
      upd_low = key_lt ? low_ff : ({1'b0, mid_ff} + CNT_W'(1));
   end

   // Midpoint of the bounds in use: registered ones at the first probe
   always_comb begin
      src_low = cmd.step ? upd_low : low_ff;
      src_hi1 = cmd.step ? upd_hi1 : hi1_ff;
      mid_sum = {1'b0, src_low} + {1'b0, src_hi1} - (CNT_W + 1)'(1);
      mid_in  = mid_sum[ADDR_W:1];
   end

   assign status.empty = !(low_ff < hi1_ff);
   assign status.hit   = hit_now;
   assign status.more  = upd_low < upd_hi1;

   assign mid_wide = WW'(mid_ff);

   // Search state and result registers
   always_ff @(posedge clock) begin
      if (cmd.init) begin
         key_ff <= req_search_key;
         low_ff <= '0;
         hi1_ff <= size_clamp[CNT_W-1:0];
      end else if (cmd.step) begin
         low_ff <= upd_low;
         hi1_ff <= upd_hi1;
      end
      if (cmd.probe) begin
         mid_ff <= mid_in;
      end
      if (cmd.finish) begin
         res_found_ff <= cmd.step & hit_now;
         res_idx_ff   <= (cmd.step & hit_now) ? mid_wide[stbs_pkg::IDX_W-1:0] : '0;
      end
      if (cmd.publish) begin
         rsp_found_ff <= res_found_ff;
         rsp_idx_ff   <= res_idx_ff;
      end
   end

   assign rsp_found       = rsp_found_ff;
   assign rsp_match_index = rsp_idx_ff;

endmodule

`default_nettype wire

[rtl/stbs_ctrl.sv]
`default_nettype none

module stbs_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_action,
   output logic                          req_ready,
   input  wire logic                     rsp_ready,
   output logic                          rsp_valid,
   input  wire stbs_pkg::dp_status_type  status,
   output stbs_pkg::ctrl_cmd_type        cmd
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_START = 4'b0010,
      S_STEP  = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // Sequence the search and the output register
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action == stbs_pkg::ACT_SEARCH) begin
                  cmd.init = 1'b1;
                  state_in = S_START;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         S_START: begin
            cmd.probe = 1'b1;
            if (status.empty) begin
               cmd.finish = 1'b1;
               state_in   = S_DONE;
            end else begin
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            cmd.step = 1'b1;
            if (status.hit || !status.more) begin
               cmd.finish = 1'b1;
               state_in   = S_DONE;
            end else begin
               cmd.probe = 1'b1;
            end
         end
         S_DONE: begin
            // hold the outcome until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_search_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_action == stbs_pkg::ACT_SEARCH) |=> state_ff == S_START)
      else $error("search beat did not start a search");

   a_start_moves_on: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_START |=> (state_ff == S_STEP || state_ff == S_DONE))
      else $error("first probe did not advance");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside the done state");

   a_done_free_publishes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !rsp_valid_ff) |=> (state_ff == S_IDLE && rsp_valid_ff))
      else $error("free output register not loaded");

endmodule

`default_nettype wire

[rtl/sorted_table_binary_search_top.sv]
// Binary search over a sorted table of signed 32-bit entries.
// req_bus carries one item per beat: action 0 stores entry_value at
// write_index (ignored when the index is beyond the table), action 1
// searches for search_key over the first table_size entries.
// csr_bus writes table_size and is always ready; the user must write it
// only while the block is idle, and the block does not enforce this.
// Values above the table depth cover the whole table. rsp_bus returns
// found and match_index for each search (index 0 when the key is
// absent); loads give no beat. Loads may follow back to back. A search
// makes at most ceil(log2(table_size + 1)) probes, so 11 for a full
// 1024-entry table: the start state issues the first, and each step
// state compares the entry from the RAM's registered read and picks the
// next probe address until a hit or an empty range. The next item is
// taken once the result sits in the output register. Reset clears
// table_size and the response valid flag; table contents are undefined
// until loaded. If the receiver stalls, the result holds in the output
// register, loads and one further search still run, and that search
// waits for the register to empty before the block goes idle.
`default_nettype none

module sorted_table_binary_search_top #(
   parameter int TABLE_DEPTH = 1024
) (
   input wire logic  clock,
   input wire logic  reset,
   stbs_req_if.sink  req_bus,
   stbs_rsp_if.source rsp_bus,
   stbs_csr_if.sink  csr_bus
);

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   stbs_pkg::ctrl_cmd_type  cmd;
   stbs_pkg::dp_status_type status;

   // Configuration writes are taken at once
   assign csr_bus.ready = 1'b1;

   stbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_action (req_bus.action),
      .req_ready  (req_bus.ready),
      .rsp_ready  (rsp_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .status     (status),
      .cmd        (cmd)
   );

   stbs_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_bus.valid),
      .csr_table_size  (csr_bus.table_size),
      .req_write_index (req_bus.write_index),
      .req_entry_value (req_bus.entry_value),
      .req_search_key  (req_bus.search_key),
      .cmd             (cmd),
      .status          (status),
      .rsp_found       (rsp_bus.found),
      .rsp_match_index (rsp_bus.match_index)
   );

endmodule

`default_nettype wire
